### hdl/apdc_pkg.sv
package apdc_pkg;

  // samples averaged per control update (power of two, 1 to 16)
  localparam int unsigned AVG_SAMPLES = 4;
  localparam int unsigned AVG_LOG2    = $clog2(AVG_SAMPLES);
  localparam int unsigned CNT_W       = (AVG_SAMPLES > 1) ? $clog2(AVG_SAMPLES) : 1;

  // field widths
  localparam int unsigned SAMPLE_W = 12;
  localparam int unsigned SUM_W    = 16;
  localparam int unsigned ERR_W    = 13;
  localparam int unsigned DIFF_W   = 14;
  localparam int unsigned INTEG_W  = 32;
  localparam int unsigned GAIN_W   = 16;
  localparam int unsigned DUTY_W   = 10;
  localparam int unsigned FRAC_W   = 8;
  localparam int unsigned P_W      = GAIN_W + ERR_W;
  localparam int unsigned I_W      = GAIN_W + INTEG_W;
  localparam int unsigned D_W      = GAIN_W + DIFF_W;
  localparam int unsigned TOTAL_W  = I_W + 2;
  localparam int unsigned LIM_W    = DUTY_W + FRAC_W;

  // stream and configuration port widths
  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 16;
  localparam int unsigned CFG_ADDR_W  = 3;
  localparam int unsigned CFG_DATA_W  = 16;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_SETPOINT  = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_KP        = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_KI_DT     = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_KD_PER_DT = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_DUTY_MIN  = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_DUTY_MAX  = 3'd5;

  // reset value of the upper duty limit
  localparam logic [DUTY_W-1:0] DUTY_MAX_RESET = 10'd999;

  // error value at which the derivative term is dropped
  localparam logic signed [ERR_W-1:0] D_SKIP_ERR = 13'sd1;

  // saturation limits of the integral
  localparam logic [INTEG_W-1:0] INTEG_POS_SAT = 32'h7FFF_FFFF;
  localparam logic [INTEG_W-1:0] INTEG_NEG_SAT = 32'h8000_0000;

endpackage

### hdl/averaged_pid_duty_controller.sv
// channel | direction | handshake              | word contents
// in_     | slave     | in_tvalid / in_tready  | sensor_sample
// out_    | master    | out_tvalid / out_tready| duty
// cfg_    | write     | cfg_we                 | register index and value
//
// one sample per cycle while in_tready is high; every AVG_SAMPLES-th sample yields a duty word
// an accepted sample loads the input stage of the five-stage pipe
// (input, error/integral, multipliers, sum, clamp)
// empty stages collapse, so samples keep flowing while a duty word waits
// rst_n clears the pipe, the group accumulator, the loop state and the registers
module averaged_pid_duty_controller (
  input  logic                                clk,
  input  logic                                rst_n,
  // sensor sample words
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [apdc_pkg::IN_TDATA_W-1:0]     in_tdata,   // [11:0] sensor_sample
  // duty words
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [apdc_pkg::OUT_TDATA_W-1:0]    out_tdata,  // [9:0] duty
  // register writes
  input  logic                                cfg_we,
  input  logic [apdc_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [apdc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  // configuration registers
  logic [apdc_pkg::SAMPLE_W-1:0]       setpoint_r;
  logic signed [apdc_pkg::GAIN_W-1:0]  kp_r;
  logic signed [apdc_pkg::GAIN_W-1:0]  ki_r;
  logic signed [apdc_pkg::GAIN_W-1:0]  kd_r;
  logic [apdc_pkg::DUTY_W-1:0]         duty_min_r;
  logic [apdc_pkg::DUTY_W-1:0]         duty_max_r;

  // loop state
  logic [apdc_pkg::SUM_W-1:0]          sum_r;
  logic [apdc_pkg::CNT_W-1:0]          cnt_r;
  logic signed [apdc_pkg::INTEG_W-1:0] integ_r;
  logic signed [apdc_pkg::ERR_W-1:0]   prev_err_r;

  // pipe stages
  logic                                s1_v_r;
  logic [apdc_pkg::SAMPLE_W-1:0]       s1_sample_r;
  logic                                s2_v_r;
  logic signed [apdc_pkg::ERR_W-1:0]   s2_err_r;
  logic signed [apdc_pkg::INTEG_W-1:0] s2_integ_r;
  logic signed [apdc_pkg::DIFF_W-1:0]  s2_diff_r;
  logic                                s3_v_r;
  logic signed [apdc_pkg::P_W-1:0]     s3_p_r;
  logic signed [apdc_pkg::I_W-1:0]     s3_i_r;
  logic signed [apdc_pkg::D_W-1:0]     s3_d_r;
  logic                                s4_v_r;
  logic signed [apdc_pkg::TOTAL_W-1:0] s4_total_r;
  logic                                s5_v_r;
  logic [apdc_pkg::DUTY_W-1:0]         s5_duty_r;

  // stage load enables
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  // stage 2 combinational
  logic [apdc_pkg::SUM_W-1:0]          sum_nxt;
  logic                                grp_end;
  logic [apdc_pkg::SAMPLE_W-1:0]       avg;
  logic signed [apdc_pkg::ERR_W-1:0]   err_nxt;
  logic signed [apdc_pkg::INTEG_W:0]   integ_wide;
  logic signed [apdc_pkg::INTEG_W-1:0] integ_nxt;
  logic signed [apdc_pkg::DIFF_W-1:0]  diff_nxt;

  // stage 4 and 5 combinational
  logic signed [apdc_pkg::TOTAL_W-1:0] total_nxt;
  logic signed [apdc_pkg::TOTAL_W-1:0] lim_lo;
  logic signed [apdc_pkg::TOTAL_W-1:0] lim_hi;
  logic [apdc_pkg::DUTY_W-1:0]         duty_nxt;

  // ready chain: a stage may load when it is empty or the next one loads
  assign rdy5 = !s5_v_r || out_tready;
  assign rdy4 = !s4_v_r || rdy5;
  assign rdy3 = !s3_v_r || rdy4;
  assign rdy2 = !s2_v_r || rdy3;
  assign rdy1 = !s1_v_r || rdy2;
  assign in_tready = rdy1;

  assign out_tvalid = s5_v_r;
  assign out_tdata  = {{(apdc_pkg::OUT_TDATA_W - apdc_pkg::DUTY_W){1'b0}}, s5_duty_r};

  // register writes, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      setpoint_r <= '0;
      kp_r       <= '0;
      ki_r       <= '0;
      kd_r       <= '0;
      duty_min_r <= '0;
      duty_max_r <= apdc_pkg::DUTY_MAX_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        apdc_pkg::REG_SETPOINT:  setpoint_r <= cfg_wdata[apdc_pkg::SAMPLE_W-1:0];
        apdc_pkg::REG_KP:        kp_r       <= $signed(cfg_wdata);
        apdc_pkg::REG_KI_DT:     ki_r       <= $signed(cfg_wdata);
        apdc_pkg::REG_KD_PER_DT: kd_r       <= $signed(cfg_wdata);
        apdc_pkg::REG_DUTY_MIN:  duty_min_r <= cfg_wdata[apdc_pkg::DUTY_W-1:0];
        apdc_pkg::REG_DUTY_MAX:  duty_max_r <= cfg_wdata[apdc_pkg::DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (rdy1) begin
      s1_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_tvalid) begin
      s1_sample_r <= in_tdata[apdc_pkg::SAMPLE_W-1:0];
    end
  end

  // group sum, average, error, saturating integral and error difference
  always_comb begin
    sum_nxt    = sum_r + apdc_pkg::SUM_W'(s1_sample_r);
    grp_end    = (cnt_r == apdc_pkg::CNT_W'(apdc_pkg::AVG_SAMPLES - 1));
    avg        = apdc_pkg::SAMPLE_W'(sum_nxt >> apdc_pkg::AVG_LOG2);
    err_nxt    = $signed({1'b0, setpoint_r}) - $signed({1'b0, avg});
    integ_wide = $signed({integ_r[apdc_pkg::INTEG_W-1], integ_r})
                 + $signed({{(apdc_pkg::INTEG_W + 1 - apdc_pkg::ERR_W)
                   {err_nxt[apdc_pkg::ERR_W-1]}}, err_nxt});
    if (integ_wide[apdc_pkg::INTEG_W] != integ_wide[apdc_pkg::INTEG_W-1]) begin
      integ_nxt = integ_wide[apdc_pkg::INTEG_W] ? $signed(apdc_pkg::INTEG_NEG_SAT)
                                                : $signed(apdc_pkg::INTEG_POS_SAT);
    end else begin
      integ_nxt = integ_wide[apdc_pkg::INTEG_W-1:0];
    end
    // derivative dropped when the error is exactly one
    if (err_nxt == apdc_pkg::D_SKIP_ERR) begin
      diff_nxt = '0;
    end else begin
      diff_nxt = $signed({err_nxt[apdc_pkg::ERR_W-1], err_nxt})
                 - $signed({prev_err_r[apdc_pkg::ERR_W-1], prev_err_r});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r      <= '0;
      cnt_r      <= '0;
      integ_r    <= '0;
      prev_err_r <= '0;
      s2_v_r     <= 1'b0;
    end else if (rdy2) begin
      s2_v_r <= s1_v_r && grp_end;
      if (s1_v_r) begin
        if (grp_end) begin
          sum_r      <= '0;
          cnt_r      <= '0;
          integ_r    <= integ_nxt;
          prev_err_r <= err_nxt;
        end else begin
          sum_r <= sum_nxt;
          cnt_r <= cnt_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && s1_v_r && grp_end) begin
      s2_err_r   <= err_nxt;
      s2_integ_r <= integ_nxt;
      s2_diff_r  <= diff_nxt;
    end
  end

  // the three gain products
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (rdy3) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && s2_v_r) begin
      s3_p_r <= kp_r * s2_err_r;
      s3_i_r <= ki_r * s2_integ_r;
      s3_d_r <= kd_r * s2_diff_r;
    end
  end

  // sum of terms in q.8
  assign total_nxt = $signed({{(apdc_pkg::TOTAL_W - apdc_pkg::P_W){s3_p_r[apdc_pkg::P_W-1]}},
                               s3_p_r})
                   + $signed({{(apdc_pkg::TOTAL_W - apdc_pkg::I_W){s3_i_r[apdc_pkg::I_W-1]}},
                               s3_i_r})
                   + $signed({{(apdc_pkg::TOTAL_W - apdc_pkg::D_W){s3_d_r[apdc_pkg::D_W-1]}},
                               s3_d_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else if (rdy4) begin
      s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4 && s3_v_r) begin
      s4_total_r <= total_nxt;
    end
  end

  // clamp to the duty limits, lower test first
  always_comb begin
    lim_lo = $signed({{(apdc_pkg::TOTAL_W - apdc_pkg::LIM_W){1'b0}}, duty_min_r,
                      {apdc_pkg::FRAC_W{1'b0}}});
    lim_hi = $signed({{(apdc_pkg::TOTAL_W - apdc_pkg::LIM_W){1'b0}}, duty_max_r,
                      {apdc_pkg::FRAC_W{1'b0}}});
    if (s4_total_r < lim_lo) begin
      duty_nxt = duty_min_r;
    end else if (s4_total_r > lim_hi) begin
      duty_nxt = duty_max_r;
    end else begin
      duty_nxt = s4_total_r[apdc_pkg::LIM_W-1:apdc_pkg::FRAC_W];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_v_r <= 1'b0;
    end else if (rdy5) begin
      s5_v_r <= s4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy5 && s4_v_r) begin
      s5_duty_r <= duty_nxt;
    end
  end

endmodule
